@@ hdl/hps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the heading PID steering core: channel
// payloads, action and register codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int HDG_W      = 16;  // heading, error, limits (signed 16)
  localparam int TICK_W     = 32;  // elapsed tick count
  localparam int SPD_W      = 16;  // wheel and rotate speeds
  localparam int GAIN_W     = 16;  // Q8.8 gains
  localparam int FRAC_W     = 8;   // fraction bits of Q8.8
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;   // counter of one iterative phase
  localparam int STEPS      = 16;  // bits handled per divide or multiply
  localparam int GAIN_CLAMP_SHIFT = 40;
  // accumulator floor: clamped gain (41 bits + sign) times a 16-bit magnitude
  localparam int ACC_MIN_W  = GAIN_CLAMP_SHIFT + 2 + HDG_W;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_DRIVE  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 4'd0,
    CFG_OOB      = 4'd1,
    CFG_DEADBAND = 4'd2,
    CFG_FULL_SPD = 4'd3,
    CFG_ROT_SPD  = 4'd4,
    CFG_GAIN_P   = 4'd5,
    CFG_GAIN_I   = 4'd6,
    CFG_GAIN_D   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [HDG_W-1:0]  heading;
    logic [TICK_W-1:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    action_t           action;
    logic              rotate_clockwise;
    logic [HDG_W-1:0]  rotate_amount;
    logic [SPD_W-1:0]  rotate_rate;
    logic [SPD_W-1:0]  left_speed;
    logic [SPD_W-1:0]  right_speed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_SUM,
    ST_MUL_D,
    ST_MUL_I,
    ST_CLAMP,
    ST_MUL_S,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t state;
    logic   last;     // final step of an iterative phase
  } seq_ctrl_t;

  typedef struct packed {
    logic start;      // input transaction taken
    logic pid_go;     // error lies in the PID band
    logic out_free;   // result register can take a new item
  } seq_stat_t;

endpackage

@@ hdl/hps_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_in_if
// Input channel: valid/ready handshake carrying one heading sample.
// ----------------------------------------------------------------------------
interface hps_in_if;
  import hps_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/hps_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_out_if
// Result channel: valid/ready handshake carrying one steering command.
// ----------------------------------------------------------------------------
interface hps_out_if;
  import hps_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/hps_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_alu
// Shared adder/subtractor used for the divide steps, the integral update
// and every shift-and-add multiply step.
// ----------------------------------------------------------------------------
module hps_alu #(
  parameter int W = 58
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y
);

  logic [W-1:0] b_op;

  // invert and carry in for subtraction
  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + W'(sub);

endmodule

@@ hdl/hps_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_seq
// Sequencer: steps one item through error, then divide, integral, three
// multiplies (PID items only) and result hand-off, with one step counter.
// ----------------------------------------------------------------------------
module hps_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  hps_pkg::seq_stat_t stat,
  output hps_pkg::seq_ctrl_t ctrl
);
  import hps_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              last;

  assign last = (cnt_r == STEP_W'(STEPS - 1));

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state; the counter runs only in iterative phases and wraps to zero
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (stat.start) state_nxt = ST_ERR;
      end
      ST_ERR: begin
        state_nxt = stat.pid_go ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_nxt = ST_MUL_S;
      end
      ST_MUL_S: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ctrl.state = state_r;
  assign ctrl.last  = last;

endmodule

@@ hdl/heading_pid_steering_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_steering_core
// Heading-hold steering for a differential-drive vehicle: rotate command
// at or beyond the bound, PID wheel speeds between deadband and bound.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch takes one heading sample and the ticks since the last correction
//    per transaction; out_ch returns exactly one command per sample.
//  - Registers are written through cfg_wr_en/cfg_index/cfg_data while the block
//    is idle (a user duty the block never checks); unknown indexes are ignored.
//  - Rotate and no-change results pass only through the error and done states,
//    and the next sample is taken once the sequencer is back in idle. A PID
//    drive result also takes a 16-step restoring divide, the integral update
//    and three 16-step shift-and-add multiplies, all on one shared adder, with
//    a gain clamp before the last multiply.
//  - in_ch.ready is high only while the sequencer is idle, so one item is in
//    work at a time; the next sample may enter while the last result still
//    waits in the output register.
//  - A stalled receiver holds the result; the sequencer then waits in its
//    final state until the output register is free.
//  - Reset restores the register defaults and clears the integral and the
//    previous error.
// ----------------------------------------------------------------------------
module heading_pid_steering_core #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hps_in_if.sink                           in_ch,
  hps_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  logic [hps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hps_pkg::*;

  localparam int SW = SUM_WIDTH;
  localparam int AW = (SW + 18 > ACC_MIN_W) ? SW + 18 : ACC_MIN_W;

  localparam logic [AW-1:0] G_HI =
    {{(AW - GAIN_CLAMP_SHIFT - 1){1'b0}}, 1'b1, {GAIN_CLAMP_SHIFT{1'b0}}};
  localparam logic [AW-1:0] G_LO =
    {{(AW - GAIN_CLAMP_SHIFT){1'b1}}, {GAIN_CLAMP_SHIFT{1'b0}}};
  localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW - 1){1'b0}}};

  // configuration registers
  logic signed [HDG_W-1:0]  setpoint_r;
  logic [HDG_W-2:0]         oob_r;
  logic [HDG_W-2:0]         db_r;
  logic [SPD_W-1:0]         fs_r;
  logic [SPD_W-1:0]         rs_r;
  logic signed [GAIN_W-1:0] gp_r, gi_r, gd_r;

  // controller state
  logic signed [SW-1:0]     error_sum_r;
  logic signed [HDG_W-1:0]  last_error_r;

  // item and datapath registers
  logic signed [HDG_W-1:0]  heading_r;
  logic [TICK_W-1:0]        div_r;
  logic signed [HDG_W-1:0]  err_r;
  logic [HDG_W-1:0]         mag_r;
  logic                     pid_r;
  action_t                  act_r;
  logic                     cw_r;
  logic [HDG_W-1:0]         amt_r;
  logic [SPD_W-1:0]         rate_r;
  logic [TICK_W-1:0]        rem_r;
  logic [STEPS-1:0]         dvd_r;
  logic [STEPS-1:0]         q_r;
  logic                     dneg_r;
  logic [AW-1:0]            acc_r;
  logic [AW-1:0]            x_r;
  logic [STEPS-1:0]         y_r;
  logic                     ysgn_r;
  logic                     neg_r;

  logic                     out_valid_r;
  out_item_t                out_data_r;

  seq_ctrl_t                ctrl;
  seq_stat_t                stat;

  logic signed [HDG_W:0]    err_wide;
  logic signed [HDG_W-1:0]  err_sat;
  logic [HDG_W-1:0]         err_abs;
  logic                     err_nz;
  logic                     err_pos;
  logic                     oob_hit;
  logic                     pid_go;
  logic signed [HDG_W:0]    diff;
  logic [HDG_W:0]           diff_abs;
  logic signed [HDG_W:0]    deriv;
  logic [AW-1:0]            alu_a, alu_b, alu_y;
  logic                     alu_sub;
  logic                     div_ok;
  logic                     sum_ovf;
  logic [SW-1:0]            sum_sat;
  logic [AW-1:0]            g_clamp;
  logic                     s_pos;
  logic [AW-FRAC_W-1:0]     s_hi;
  logic [SPD_W-1:0]         spd;
  logic                     out_free;

  // sequencer
  hps_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign in_ch.ready   = (ctrl.state == ST_IDLE);
  assign out_free      = !out_valid_r || out_ch.ready;
  assign stat.start    = in_ch.valid && in_ch.ready;
  assign stat.out_free = out_free;
  assign stat.pid_go   = pid_go;

  // error, saturated to 16 bits, and its magnitude
  always_comb begin
    err_wide = $signed({setpoint_r[HDG_W-1], setpoint_r})
             - $signed({heading_r[HDG_W-1], heading_r});
    if (err_wide[HDG_W] != err_wide[HDG_W-1]) begin
      err_sat = err_wide[HDG_W] ? $signed({1'b1, {(HDG_W - 1){1'b0}}})
                                : $signed({1'b0, {(HDG_W - 1){1'b1}}});
    end else begin
      err_sat = err_wide[HDG_W-1:0];
    end
    err_abs = err_sat[HDG_W-1] ? (~err_sat + 1'b1) : err_sat;
    err_nz  = (err_sat != '0);
    err_pos = !err_sat[HDG_W-1] && err_nz;
    oob_hit = (err_abs >= {1'b0, oob_r});
    pid_go  = !oob_hit && (err_abs > {1'b0, db_r});
    diff     = $signed({err_sat[HDG_W-1], err_sat})
             - $signed({last_error_r[HDG_W-1], last_error_r});
    diff_abs = diff[HDG_W] ? (~diff + 1'b1) : diff;
  end

  // signed quotient from the unsigned divide
  assign deriv = dneg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  // operand selection for the shared adder
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      ST_DIV: begin
        alu_a   = AW'({rem_r, dvd_r[STEPS-1]});
        alu_b   = AW'(div_r);
        alu_sub = 1'b1;
      end
      ST_SUM: begin
        alu_a = AW'(error_sum_r);
        alu_b = AW'(err_r);
      end
      ST_MUL_D, ST_MUL_I, ST_MUL_S: begin
        alu_b   = y_r[0] ? x_r : '0;
        alu_sub = neg_r ^ (ysgn_r && ctrl.last);
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  hps_alu #(.W(AW)) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .sub(alu_sub),
    .y  (alu_y)
  );

  // divide step result, integral saturation, gain clamp
  always_comb begin
    div_ok  = !alu_y[AW-1];
    sum_ovf = (alu_y[AW-1:SW-1] != '0) && (alu_y[AW-1:SW-1] != '1);
    sum_sat = sum_ovf ? (alu_y[AW-1] ? SUM_MIN : SUM_MAX) : alu_y[SW-1:0];
    if ($signed(acc_r) > $signed(G_HI)) begin
      g_clamp = G_HI;
    end else if ($signed(acc_r) < $signed(G_LO)) begin
      g_clamp = G_LO;
    end else begin
      g_clamp = acc_r;
    end
  end

  // wheel speed from the Q8.8 result: drop fraction, limit to 0..full speed
  always_comb begin
    s_pos = !acc_r[AW-1] && (acc_r != '0);
    s_hi  = acc_r[AW-1:FRAC_W];
    if (!s_pos) begin
      spd = '0;
    end else if (s_hi > (AW - FRAC_W)'(fs_r)) begin
      spd = fs_r;
    end else begin
      spd = s_hi[SPD_W-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      oob_r      <= 15'd30;
      db_r       <= 15'd2;
      fs_r       <= 16'd1000;
      rs_r       <= 16'd500;
      gp_r       <= 16'sd256;
      gi_r       <= '0;
      gd_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SETPOINT: setpoint_r <= cfg_data;
        CFG_OOB:      oob_r      <= cfg_data[HDG_W-2:0];
        CFG_DEADBAND: db_r       <= cfg_data[HDG_W-2:0];
        CFG_FULL_SPD: fs_r       <= cfg_data;
        CFG_ROT_SPD:  rs_r       <= cfg_data;
        CFG_GAIN_P:   gp_r       <= cfg_data;
        CFG_GAIN_I:   gi_r       <= cfg_data;
        CFG_GAIN_D:   gd_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // integral and previous error: clear at or beyond the bound, update on a PID step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      case (ctrl.state)
        ST_ERR: begin
          if (oob_hit) begin
            error_sum_r  <= '0;
            last_error_r <= '0;
          end else if (stat.pid_go) begin
            last_error_r <= err_sat;
          end
        end
        ST_SUM: begin
          error_sum_r <= sum_sat;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (stat.start) begin
      heading_r <= in_ch.data.heading;
      div_r     <= (in_ch.data.elapsed_ticks == '0) ? TICK_W'(1)
                                                    : in_ch.data.elapsed_ticks;
    end
    case (ctrl.state)
      ST_ERR: begin
        err_r  <= err_sat;
        mag_r  <= err_abs;
        pid_r  <= stat.pid_go;
        act_r  <= ACT_NONE;
        cw_r   <= 1'b0;
        amt_r  <= '0;
        rate_r <= '0;
        if (oob_hit && err_nz) begin
          act_r  <= ACT_ROTATE;
          cw_r   <= err_pos;
          amt_r  <= err_abs;
          rate_r <= rs_r;
        end
        dneg_r <= diff[HDG_W];
        dvd_r  <= diff_abs[STEPS-1:0];
        rem_r  <= '0;
        q_r    <= '0;
      end
      ST_DIV: begin
        dvd_r <= {dvd_r[STEPS-2:0], 1'b0};
        q_r   <= {q_r[STEPS-2:0], div_ok};
        rem_r <= div_ok ? alu_y[TICK_W-1:0] : {rem_r[TICK_W-2:0], dvd_r[STEPS-1]};
      end
      ST_SUM: begin
        // set up gain_p + gain_d * derivative
        acc_r  <= AW'(gp_r);
        x_r    <= AW'(deriv);
        y_r    <= gd_r;
        ysgn_r <= 1'b1;
        neg_r  <= 1'b0;
      end
      ST_MUL_D: begin
        acc_r <= alu_y;
        if (ctrl.last) begin
          // continue with gain_i * integral
          x_r <= AW'(error_sum_r);
          y_r <= gi_r;
        end else begin
          x_r <= {x_r[AW-2:0], 1'b0};
          y_r <= {1'b0, y_r[STEPS-1:1]};
        end
      end
      ST_MUL_I, ST_MUL_S: begin
        acc_r <= alu_y;
        x_r   <= {x_r[AW-2:0], 1'b0};
        y_r   <= {1'b0, y_r[STEPS-1:1]};
      end
      ST_CLAMP: begin
        // full speed in Q8.8 minus magnitude times clamped gain
        acc_r  <= AW'({fs_r, {FRAC_W{1'b0}}});
        x_r    <= g_clamp;
        y_r    <= mag_r;
        ysgn_r <= 1'b0;
        neg_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register: load when the result slot is free, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.state == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.state == ST_DONE && out_free) begin
      if (pid_r) begin
        out_data_r.action           <= ACT_DRIVE;
        out_data_r.rotate_clockwise <= 1'b0;
        out_data_r.rotate_amount    <= '0;
        out_data_r.rotate_rate      <= '0;
        out_data_r.left_speed       <= err_r[HDG_W-1] ? fs_r : spd;
        out_data_r.right_speed      <= err_r[HDG_W-1] ? spd : fs_r;
      end else begin
        out_data_r.action           <= act_r;
        out_data_r.rotate_clockwise <= cw_r;
        out_data_r.rotate_amount    <= amt_r;
        out_data_r.rotate_rate      <= rate_r;
        out_data_r.left_speed       <= '0;
        out_data_r.right_speed      <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // checks
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.state == ST_DIV) |-> (rem_r < div_r))
    else $error("divide remainder not below divisor");

  a_drive_full_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.action == ACT_DRIVE) |->
      (out_ch.data.left_speed == fs_r || out_ch.data.right_speed == fs_r))
    else $error("drive command without a wheel at full speed");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.action == ACT_NONE) |->
      (!out_ch.data.rotate_clockwise && out_ch.data.rotate_amount == '0 &&
       out_ch.data.rotate_rate == '0 && out_ch.data.left_speed == '0 &&
       out_ch.data.right_speed == '0))
    else $error("no-change command with non-zero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    stat.start |=> !in_ch.ready)
    else $error("input taken while an item is in work");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heading_pid_steering_core. Headings and tick counts
// go in over the input channel, and a local model of the steering law
// predicts one command for each of them. Each command that comes out is
// checked field by field against that prediction. Register writes happen
// only once the core has drained. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import hps_pkg::*;

  localparam int     SUM_WIDTH     = 32;
  localparam longint SUM_HI        = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO        = -SUM_HI - 1;
  localparam longint GAIN_LIM      = longint'(1) <<< GAIN_CLAMP_SHIFT;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd11;  // not a register
  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_CYCLES  = 100;

  typedef enum logic [1:0] {JOB_SAMPLE, JOB_REG, JOB_SETTLE} job_kind_t;

  typedef struct {
    job_kind_t              kind;
    in_item_t               sample;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } job_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hps_in_if  steer_in ();
  hps_out_if steer_out ();

  heading_pid_steering_core #(.SUM_WIDTH(SUM_WIDTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (steer_in),
    .out_ch    (steer_out),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model copy of the registers, at their reset values
  logic signed [15:0] sp_reg   = 16'sd0;
  logic        [14:0] oob_reg  = 15'd30;
  logic        [14:0] dead_reg = 15'd2;
  logic        [15:0] full_reg = 16'd1000;
  logic        [15:0] rot_reg  = 16'd500;
  logic signed [15:0] kp_reg   = 16'sd256;
  logic signed [15:0] ki_reg   = 16'sd0;
  logic signed [15:0] kd_reg   = 16'sd0;

  // model PID memory
  longint integral_acc = 0;
  longint prev_error   = 0;

  job_t      job_q[$];
  out_item_t pending_cmds[$];

  int        mismatch_count = 0;
  bit        quiet = 0;       // no new gaps or stalls on either side while set
  bit        in_fire = 0;
  int        gap_left = 0;
  int        settle_cnt = 0;
  int        stall_left = 0;
  bit        valid_nx;
  bit        wr_nx;
  bit        ready_nx;
  out_item_t want;
  out_item_t got;

  // planned register values, used only to shape the stimulus
  int plan_sp   = 0;
  int plan_oob  = 30;
  int plan_dead = 2;

  // --------------------------------------------------------------------------
  // Steering law
  // --------------------------------------------------------------------------
  function automatic out_item_t steering_law(in_item_t item);
    longint    err;
    longint    mag;
    longint    span;
    longint    deriv;
    longint    gsum;
    longint    spd_q;
    longint    spd;
    out_item_t res;
    res = '0;
    err = longint'(sp_reg) - longint'($signed(item.heading));
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    mag = (err < 0) ? -err : err;

    if (mag >= longint'(oob_reg)) begin
      // out of bound: rotate in place unless the error is zero, and forget the PID memory
      if (err != 0) begin
        res.action           = ACT_ROTATE;
        res.rotate_clockwise = (err > 0);
        res.rotate_amount    = mag[15:0];
        res.rotate_rate      = rot_reg;
      end
      integral_acc = 0;
      prev_error   = 0;
    end else if (mag > longint'(dead_reg)) begin
      span  = (item.elapsed_ticks == '0) ? 1 : longint'({32'd0, item.elapsed_ticks});
      deriv = (err - prev_error) / span;
      integral_acc = integral_acc + err;
      if (integral_acc > SUM_HI) integral_acc = SUM_HI;
      if (integral_acc < SUM_LO) integral_acc = SUM_LO;

      gsum = longint'(kp_reg) + longint'(kd_reg) * deriv + longint'(ki_reg) * integral_acc;
      if (gsum > GAIN_LIM) gsum = GAIN_LIM;
      if (gsum < -GAIN_LIM) gsum = -GAIN_LIM;

      // slow the wheel on the side of the error, Q8.8 then truncate
      spd_q = longint'(full_reg) * 256 - mag * gsum;
      if (spd_q <= 0) begin
        spd = 0;
      end else begin
        spd = spd_q >>> FRAC_W;
        if (spd > longint'(full_reg)) spd = longint'(full_reg);
      end

      res.action = ACT_DRIVE;
      if (err > 0) begin
        res.left_speed  = spd[15:0];
        res.right_speed = full_reg;
      end else begin
        res.left_speed  = full_reg;
        res.right_speed = spd[15:0];
      end
      prev_error = err;
    end
    return res;
  endfunction

  task automatic write_model_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SETPOINT: sp_reg   = val;
      CFG_OOB:      oob_reg  = val[14:0];
      CFG_DEADBAND: dead_reg = val[14:0];
      CFG_FULL_SPD: full_reg = val;
      CFG_ROT_SPD:  rot_reg  = val;
      CFG_GAIN_P:   kp_reg   = val;
      CFG_GAIN_I:   ki_reg   = val;
      CFG_GAIN_D:   kd_reg   = val;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 50) return $urandom_range(1, 4);
    if (r < 75) return $urandom_range(5, 1000);
    return $urandom();
  endfunction

  // heading chosen so the error falls into each band of the planned setting, or an extreme or random heading
  function automatic logic [HDG_W-1:0] pick_heading();
    int r;
    int e;
    int h;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      e = $urandom_range(0, plan_dead);
    end else if (r < 60 && plan_oob > plan_dead + 1) begin
      e = $urandom_range(plan_dead + 1, plan_oob - 1);
    end else if (r < 78) begin
      e = $urandom_range(plan_oob, 32767);
    end else if (r < 86) begin
      return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end else begin
      return 16'($urandom());
    end
    if ($urandom_range(0, 1)) e = -e;
    h = plan_sp - e;
    return h[15:0];
  endfunction

  task automatic add_sample(logic [HDG_W-1:0] hdg, logic [TICK_W-1:0] ticks);
    job_t j;
    j = '{kind: JOB_SAMPLE, sample: '{heading: hdg, elapsed_ticks: ticks},
          reg_idx: '0, reg_val: '0};
    job_q.push_back(j);
  endtask

  task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    job_t j;
    j = '{kind: JOB_REG, sample: '0, reg_idx: idx, reg_val: val};
    job_q.push_back(j);
    case (idx)
      CFG_SETPOINT: plan_sp   = int'($signed(val));
      CFG_OOB:      plan_oob  = int'(val[14:0]);
      CFG_DEADBAND: plan_dead = int'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic add_settle();
    job_t j;
    j = '{kind: JOB_SETTLE, sample: '0, reg_idx: '0, reg_val: '0};
    job_q.push_back(j);
  endtask

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($signed($urandom_range(0, 2048)) - 1024);
    if (r < 85) return 16'($urandom());
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  function automatic logic [15:0] pick_reg_value(cfg_idx_t idx);
    int r;
    r = $urandom_range(0, 99);
    case (idx)
      CFG_SETPOINT: begin
        if (r < 70) return 16'($signed($urandom_range(0, 4000)) - 2000);
        if (r < 90) return 16'($urandom());
        return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      CFG_OOB: begin
        // bit 15 is random to check that it is dropped
        if (r < 8)  return {1'($urandom_range(0, 1)), 15'd0};
        if (r < 18) return {1'($urandom_range(0, 1)), 15'h7FFF};
        if (r < 80) return {1'($urandom_range(0, 1)), 15'($urandom_range(10, 3000))};
        return 16'($urandom());
      end
      CFG_DEADBAND: begin
        if (r < 10) return {1'($urandom_range(0, 1)), 15'd0};
        if (r < 85) return {1'($urandom_range(0, 1)), 15'($urandom_range(0, plan_oob / 4))};
        return 16'($urandom());
      end
      CFG_FULL_SPD: begin
        if (r < 8)  return 16'd0;
        if (r < 18) return 16'hFFFF;
        if (r < 80) return 16'($urandom_range(100, 5000));
        return 16'($urandom());
      end
      CFG_ROT_SPD:  return 16'($urandom());
      default:      return pick_gain();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    steer_in.valid = 1'b0;
    steer_in.data  = '0;
    steer_out.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #15_000_000;
    $display("tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus plan
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int k;
    int n;
    int h;

    // reset settings: deadband edge, both signs, both bound edges
    add_sample(16'd0, 32'd0);
    add_sample(-16'sd2, 32'd5);
    add_sample(-16'sd3, 32'd0);
    add_sample(16'sd5, 32'd1);
    add_sample(-16'sd29, 32'hFFFF_FFFF);
    add_sample(-16'sd30, 32'd2);
    add_sample(16'sd100, 32'd3);

    // every register at an extreme, plus a write to an unused index
    add_settle();
    add_reg(CFG_SETPOINT, 16'h8000);
    add_reg(CFG_OOB, 16'hFFFF);
    add_reg(CFG_DEADBAND, 16'h8000);
    add_reg(CFG_FULL_SPD, 16'hFFFF);
    add_reg(CFG_ROT_SPD, 16'hFFFF);
    add_reg(CFG_GAIN_P, 16'h8000);
    add_reg(CFG_GAIN_I, 16'h7FFF);
    add_reg(CFG_GAIN_D, 16'h8000);
    add_reg(CFG_SPARE, 16'h1234);
    add_sample(16'h7FFF, 32'd0);       // error saturates negative
    add_sample(16'h8001, 32'd0);
    add_sample(16'h8000, 32'd7);       // zero error inside the deadband
    add_sample(16'h8300, 32'hFFFF_FFFF);
    add_sample(16'h8300, 32'h8000_0000);

    add_settle();
    add_reg(CFG_SETPOINT, 16'h7FFF);
    add_reg(CFG_GAIN_P, 16'h7FFF);
    add_reg(CFG_GAIN_D, 16'h7FFF);
    add_sample(16'h8000, 32'd1);       // error saturates positive
    add_sample(16'h7FFE, 32'd0);

    // zero bound: zero error clears memory and reports no change
    add_settle();
    add_reg(CFG_OOB, 16'h0000);
    add_sample(16'h7FFF, 32'd0);
    add_sample(16'h7FFA, 32'd0);

    // zero full speed and zero gains
    add_settle();
    add_reg(CFG_OOB, 16'h7FFF);
    add_reg(CFG_FULL_SPD, 16'h0000);
    add_reg(CFG_GAIN_P, 16'h0000);
    add_reg(CFG_GAIN_I, 16'h0000);
    add_reg(CFG_GAIN_D, 16'h0000);
    add_sample(16'h7F00, 32'd0);
    add_sample(16'h8100, 32'd3);

    // huge gain terms: grow the integral under the largest integral gains
    add_settle();
    add_reg(CFG_SETPOINT, 16'h0000);
    add_reg(CFG_OOB, 16'h7FFF);
    add_reg(CFG_DEADBAND, 16'h0000);
    add_reg(CFG_FULL_SPD, 16'd1000);
    add_reg(CFG_GAIN_P, 16'h0000);
    add_reg(CFG_GAIN_I, 16'h7FFF);
    add_reg(CFG_GAIN_D, pick_gain());
    for (k = 0; k < 200; k++) begin
      h = -$urandom_range(20000, 32766);
      add_sample(h[15:0], pick_ticks());
    end
    add_settle();
    add_reg(CFG_GAIN_I, 16'h8000);
    for (k = 0; k < 30; k++) begin
      h = -$urandom_range(20000, 32766);
      add_sample(h[15:0], pick_ticks());
    end

    // random phases, each under a fresh mix of settings
    for (ph = 0; ph < 6; ph++) begin
      add_settle();
      for (k = CFG_SETPOINT; k <= CFG_GAIN_D; k++) begin
        if ($urandom_range(0, 1)) add_reg(k[CFG_IDX_W-1:0], pick_reg_value(cfg_idx_t'(k)));
      end
      if ($urandom_range(0, 3) == 0) add_reg(4'($urandom_range(8, 15)), 16'($urandom()));
      n = $urandom_range(35, 55);
      for (k = 0; k < n; k++) add_sample(pick_heading(), pick_ticks());
    end
  end

  // --------------------------------------------------------------------------
  // Driver: present samples and register writes at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      steer_in.valid <= 1'b0;
      cfg_wr_en      <= 1'b0;
    end else begin
      valid_nx = steer_in.valid && !in_fire;   // hold until taken
      wr_nx    = 1'b0;
      if (!valid_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (job_q.size() != 0) begin
          case (job_q[0].kind)
            JOB_SAMPLE: begin
              steer_in.data <= job_q[0].sample;
              valid_nx = 1'b1;
              void'(job_q.pop_front());
              gap_left = pick_gap();
              if ($urandom_range(0, 39) == 0) quiet = !quiet;
            end
            JOB_REG: begin
              cfg_index <= job_q[0].reg_idx;
              cfg_data  <= job_q[0].reg_val;
              wr_nx = 1'b1;
              void'(job_q.pop_front());
            end
            default: begin
              // wait for every command, then let the settle counter run out
              if (pending_cmds.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(job_q.pop_front());
              end else begin
                settle_cnt++;
              end
            end
          endcase
        end
      end
      steer_in.valid <= valid_nx;
      cfg_wr_en      <= wr_nx;
    end
  end

  // Receiver: random stalls on the result channel
  always @(negedge clk) begin
    if (!rst_n) begin
      steer_out.ready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
        ready_nx = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        ready_nx = 1'b0;
      end else begin
        ready_nx = 1'b1;
      end
      steer_out.ready <= ready_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= steer_in.valid && steer_in.ready;
      if (cfg_wr_en) write_model_reg(cfg_index, cfg_data);
      if (steer_in.valid && steer_in.ready) pending_cmds.push_back(steering_law(steer_in.data));
      if (steer_out.valid && steer_out.ready) begin
        got = steer_out.data;
        if (pending_cmds.size() == 0) begin
          $display("%0t ns: unexpected command, expected none, actual action %0d",
                   $time, got.action);
          mismatch_count++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("action", want.action, got.action);
          check_field("rotate_clockwise", want.rotate_clockwise, got.rotate_clockwise);
          check_field("rotate_amount", want.rotate_amount, got.rotate_amount);
          check_field("rotate_rate", want.rotate_rate, got.rotate_rate);
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("right_speed", want.right_speed, got.right_speed);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (job_q.size() != 0 || steer_in.valid || pending_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
